// File: design/assert_macros.svh
// Assertion macros shared by the page fault and trim engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: design/pft_pkg.sv
// Types and constants of the page fault and trim engine
`timescale 1ns / 1ps
package pft_pkg;

  localparam int PAGE_COUNT = 512;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = $clog2(PAGE_COUNT);
  localparam int FREE_W     = $clog2(PAGE_COUNT + 1);
  localparam int VA_W       = 48;
  localparam logic [VA_W-1:0] SPAN = VA_W'(PAGE_COUNT) << PAGE_SHIFT;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TRIM   = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_VIOLATION = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;
  localparam logic [1:0] ST_TRIM_MISS = 2'd3;

  localparam logic [1:0] RES_NONE    = 2'd0;
  localparam logic [1:0] RES_MAPPED  = 2'd1;
  localparam logic [1:0] RES_RECLAIM = 2'd2;
  localparam logic [1:0] RES_NEW     = 2'd3;

  typedef struct packed {
    logic            op;
    logic [VA_W-1:0] virtual_address;
  } pft_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        resolution;
    logic [PAGE_W-1:0] page_index;
    logic [PAGE_W-1:0] frame;
    logic [FREE_W-1:0] free_left;
  } pft_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              op;
    logic              hit;
    logic [PAGE_W-1:0] page;
  } pft_cmd_t;

  // one page table entry
  typedef struct packed {
    logic              valid;
    logic              standby;
    logic [PAGE_W-1:0] frame;
  } pft_entry_t;

endpackage

// File: design/page_fault_and_trim_engine.sv
// Top level of the page fault and trim engine
//
// Input side is a queue: drive item and push; the word is taken on a clock
// edge where push is high and full is low. Result side is a queue too: the
// oldest result word sits on result while empty is low and leaves on an
// edge where pop is high. Every input word gives exactly one result word,
// in order.
// cfg_we writes window_base from cfg_data on the same edge; write it only
// while no word is in flight.
// A word passes through the command queue, the registered page table read
// and the result queue. The back end finishes each word, the page table
// RAM read and then its write-back, before it takes the next one.
// Reset (rst, synchronous) empties both queues, sets the free pool to all
// frames and then sweeps the 512-entry page table; full stays high during
// the sweep. When the receiver stalls, the two-word command queue and
// two-word result queue fill and full rises; nothing is dropped.
`timescale 1ns / 1ps
module page_fault_and_trim_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [pft_pkg::VA_W-1:0] cfg_data,
  input  logic                     push,
  output logic                     full,
  input  pft_pkg::pft_in_t         item,
  output logic                     empty,
  input  logic                     pop,
  output pft_pkg::pft_out_t        result
);
  import pft_pkg::*;

  logic     hold;
  logic     cmd_valid;
  logic     cmd_pop;
  pft_cmd_t cmd;

  pft_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .hold      (hold),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hold      (hold),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: design/pft_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pft_front.sv
// Front end: window check, page index and the command queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pft_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pft_pkg::VA_W-1:0]     cfg_data,
  input  logic                         push,
  output logic                         full,
  input  pft_pkg::pft_in_t             item,
  input  logic                         hold,
  output logic                         cmd_valid,
  output pft_pkg::pft_cmd_t            cmd,
  input  logic                         cmd_pop
);
  import pft_pkg::*;

  logic [VA_W-1:0] window_base;
  pft_cmd_t        queue [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic [VA_W:0]   diff;
  logic            accept;
  pft_cmd_t        cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
    end else if (cfg_we) begin
      window_base <= cfg_data;
    end
  end

  // borrow out of the subtract means below the window
  always_comb begin
    diff     = {1'b0, item.virtual_address} - {1'b0, window_base};
    cls.op   = item.op;
    cls.hit  = !diff[VA_W] && (diff[VA_W-1:0] < SPAN);
    cls.page = diff[PAGE_SHIFT +: PAGE_W];
  end

  assign full      = (count == 2'd2) || hold;
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (accept && !(cmd_pop && cmd_valid)) begin
      count_next = count + 2'd1;
    end else if (!accept && cmd_pop && cmd_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  `ASSERT_NEVER(a_front_no_overflow, clk, rst, count == 2'd3, "command queue count out of range")
  `ASSERT_HOLDS(a_front_ptr_track, clk, rst, (count == 2'd1) == (wr_ptr != rd_ptr),
    "command queue pointers disagree with count")

endmodule

// File: design/pft_back.sv
// Back end: page table read-modify-write, free pool and result queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pft_back (
  input  logic               clk,
  input  logic               rst,
  output logic               hold,
  input  logic               cmd_valid,
  input  pft_pkg::pft_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output pft_pkg::pft_out_t  result
);
  import pft_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [PAGE_W-1:0]   clr_idx;
  logic [FREE_W-1:0]   free_count;
  logic [FREE_W-1:0]   free_count_next;
  pft_cmd_t            cur;
  pft_entry_t          ent;
  logic [$bits(pft_entry_t)-1:0] rdata;
  logic                we;
  logic [PAGE_W-1:0]   waddr;
  pft_entry_t          wdata;
  pft_out_t            res;
  logic                res_push;
  pft_out_t            outq [2];
  logic                owr_ptr;
  logic                ord_ptr;
  logic [1:0]          ocount;
  logic                opop;

  pft_ram #(
    .WIDTH ($bits(pft_entry_t)),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cmd.page),
    .rdata (rdata)
  );

  assign ent     = rdata;
  assign hold    = (state == S_CLEAR);
  // take a command only if its result has a slot waiting
  assign cmd_pop = (state == S_IDLE) && cmd_valid && (ocount != 2'd2);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == PAGE_W'(PAGE_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_pop) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    we              = 1'b0;
    waddr           = cur.page;
    wdata           = '0;
    free_count_next = free_count;
    res_push        = 1'b0;
    res.status      = ST_OK;
    res.resolution  = RES_NONE;
    res.page_index  = cur.page;
    res.frame       = '0;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx;
    end else if (state == S_EXEC) begin
      res_push = 1'b1;
      if (!cur.hit) begin
        res.status     = ST_VIOLATION;
        res.page_index = '0;
      end else if (cur.op == OP_TRIM) begin
        if (ent.valid) begin
          we        = 1'b1;
          wdata     = '{valid: 1'b0, standby: 1'b1, frame: ent.frame};
          res.frame = ent.frame;
        end else begin
          res.status = ST_TRIM_MISS;
        end
      end else if (ent.valid) begin
        res.resolution = RES_MAPPED;
        res.frame      = ent.frame;
      end else if (ent.standby) begin
        we             = 1'b1;
        wdata          = '{valid: 1'b1, standby: 1'b0, frame: ent.frame};
        res.resolution = RES_RECLAIM;
        res.frame      = ent.frame;
      end else if (free_count == '0) begin
        res.status = ST_NO_FREE;
      end else begin
        // pool hands out frames top down, so the new frame is the new count
        free_count_next = free_count - 1'b1;
        we              = 1'b1;
        wdata           = '{valid: 1'b1, standby: 1'b0,
                            frame: free_count_next[PAGE_W-1:0]};
        res.resolution  = RES_NEW;
        res.frame       = free_count_next[PAGE_W-1:0];
      end
    end
    res.free_left = free_count_next;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      free_count <= FREE_W'(PAGE_COUNT);
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // result queue
  assign empty  = (ocount == 2'd0);
  assign opop   = pop && !empty;
  assign result = outq[ord_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      outq[owr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= '0;
    end else begin
      if (res_push) begin
        owr_ptr <= !owr_ptr;
      end
      if (opop) begin
        ord_ptr <= !ord_ptr;
      end
      if (res_push && !opop) begin
        ocount <= ocount + 2'd1;
      end else if (!res_push && opop) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

  `ASSERT_NEVER(a_back_pool_bound, clk, rst, free_count > FREE_W'(PAGE_COUNT),
    "free pool count above page count")
  `ASSERT_NEVER(a_back_slot_free, clk, rst, res_push && (ocount == 2'd2) && !opop,
    "result word pushed into a full queue")
  `ASSERT_HOLDS(a_back_one_item, clk, rst, (state == S_EXEC) |=> (state == S_IDLE),
    "table update did not finish in one cycle")

endmodule
